### src/sat_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted array table
// no dependencies
package sat_pkg;

    localparam int CFG_W = 9;

    localparam logic [1:0] KIND_INSERT     = 2'd0;
    localparam logic [1:0] KIND_LOOKUP     = 2'd1;
    localparam logic [1:0] KIND_REMOVE_IDX = 2'd2;
    localparam logic [1:0] KIND_REMOVE_KEY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_COUNT,
        POS_INDEX,
        POS_ZERO,
        POS_INC,
        POS_DEC
    } pos_sel_t;

    typedef enum logic [1:0] {
        RD_POS_M1,
        RD_POS,
        RD_POS_P1,
        RD_INDEX
    } rd_sel_t;

    typedef enum logic {
        WR_KEY,
        WR_RDATA
    } wr_sel_t;

    typedef struct packed {
        logic       load;
        pos_sel_t   pos_sel;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       finish;
        logic [1:0] fin_status;
        logic       fin_entry;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       bad_index;
        logic       pos_zero;
        logic       pos_end;
        logic       pos_last;
        logic       rdata_ge;
        logic       rdata_eq;
    } stat_t;

endpackage

### src/sat_ctrl.sv
`timescale 1ns / 1ps
// request sequencer for the sorted array table
// depends on sat_pkg; drives sat_dp through cmd_t, reads stat_t
module sat_ctrl
    import sat_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_INS_RD = 4'd2;
    localparam logic [3:0] S_INS_EV = 4'd3;
    localparam logic [3:0] S_LK_EV  = 4'd4;
    localparam logic [3:0] S_FD_RD  = 4'd5;
    localparam logic [3:0] S_FD_EV  = 4'd6;
    localparam logic [3:0] S_SH_RD  = 4'd7;
    localparam logic [3:0] S_SH_EV  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.pos_sel    = POS_HOLD;
        cmd.rd_sel     = RD_POS;
        cmd.wr_sel     = WR_KEY;
        cmd.fin_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (stat.kind)
                    KIND_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_FULL;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.pos_sel = POS_COUNT;
                            state_next  = S_INS_RD;
                        end
                    end
                    KIND_LOOKUP:
                    begin
                        if (stat.bad_index)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_BAD_INDEX;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_INDEX;
                            state_next = S_LK_EV;
                        end
                    end
                    KIND_REMOVE_IDX:
                    begin
                        if (stat.bad_index)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_BAD_INDEX;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.pos_sel = POS_INDEX;
                            state_next  = S_SH_RD;
                        end
                    end
                    default:
                    begin
                        cmd.pos_sel = POS_ZERO;
                        state_next  = S_FD_RD;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (stat.pos_zero)
                begin
                    // bottom reached: the new key lands at position zero
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS_M1;
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV:
            begin
                if (stat.rdata_ge)
                begin
                    // stored key not less than new key moves up one slot
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_RDATA;
                    cmd.pos_sel = POS_DEC;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_LK_EV:
            begin
                cmd.finish    = 1'b1;
                cmd.fin_entry = 1'b1;
                state_next    = S_IDLE;
            end
            S_FD_RD:
            begin
                if (stat.pos_end)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS;
                    state_next = S_FD_EV;
                end
            end
            S_FD_EV:
            begin
                if (stat.rdata_eq)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    cmd.pos_sel = POS_INC;
                    state_next  = S_FD_RD;
                end
            end
            S_SH_RD:
            begin
                if (stat.pos_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS_P1;
                    state_next = S_SH_EV;
                end
            end
            S_SH_EV:
            begin
                // close the gap one entry at a time
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_RDATA;
                cmd.pos_sel = POS_INC;
                state_next  = S_SH_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/sat_dp.sv
`timescale 1ns / 1ps
// datapath for the sorted array table: key memory, count, scan pointer, result registers
// depends on sat_pkg; controlled by sat_ctrl
module sat_dp
    import sat_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32,
    localparam int IDX_W    = $clog2(DEPTH),
    localparam int CNT_W    = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           in_kind,
    input  logic [KEY_WIDTH-1:0] in_key,
    input  logic [IDX_W-1:0]     in_index,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic [1:0]           status,
    output logic [KEY_WIDTH-1:0] entry,
    output logic [CNT_W-1:0]     count,
    output logic                 done
);

    localparam int LW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    logic [1:0]           kind_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]     index_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     pos_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CFG_W-1:0]     limit_reg;
    logic [KEY_WIDTH-1:0] rdata_reg;
    logic [1:0]           status_reg;
    logic [KEY_WIDTH-1:0] entry_reg;
    logic                 done_reg;

    logic [CNT_W-1:0]     raddr;
    logic [KEY_WIDTH-1:0] wdata;
    logic [CNT_W:0]       pos_plus1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= CFG_W'(256);
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            key_reg   <= in_key;
            index_reg <= in_index;
        end
        pos_reg <= pos_next;
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            entry_reg  <= cmd.fin_entry ? rdata_reg : '0;
        end
    end

    // single write port at the scan pointer, registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[pos_reg[IDX_W-1:0]] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        case (cmd.pos_sel)
            POS_COUNT: pos_next = count_reg;
            POS_INDEX: pos_next = CNT_W'(index_reg);
            POS_ZERO:  pos_next = '0;
            POS_INC:   pos_next = pos_reg + 1'b1;
            POS_DEC:   pos_next = pos_reg - 1'b1;
            default:   pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_POS_M1: raddr = pos_reg - 1'b1;
            RD_POS:    raddr = pos_reg;
            RD_POS_P1: raddr = pos_reg + 1'b1;
            RD_INDEX:  raddr = CNT_W'(index_reg);
            default:   raddr = pos_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign wdata     = (cmd.wr_sel == WR_RDATA) ? rdata_reg : key_reg;
    assign pos_plus1 = {1'b0, pos_reg} + 1'b1;

    // effective limit is the smaller of the register and the depth
    assign stat.kind      = kind_reg;
    assign stat.full      = (LW'(count_reg) >= LW'(limit_reg)) || (count_reg >= CNT_W'(DEPTH));
    assign stat.bad_index = (CNT_W'(index_reg) >= count_reg);
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.pos_end   = (pos_reg >= count_reg);
    assign stat.pos_last  = (pos_plus1 >= {1'b0, count_reg});
    assign stat.rdata_ge  = (rdata_reg >= key_reg);
    assign stat.rdata_eq  = (rdata_reg == key_reg);

    assign status = status_reg;
    assign entry  = entry_reg;
    assign count  = count_reg;
    assign done   = done_reg;

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (pos_reg < CNT_W'(DEPTH)))
        else $error("memory write beyond depth");
`endif

endmodule

### src/sorted_array_table_unit.sv
`timescale 1ns / 1ps
// sequence: after the start transfer a refused request finishes at the check, a lookup after its memory read;
// insert moves up each stored entry not less than the key, then writes the key into the freed slot;
// remove-at-index moves each later entry down, remove-key first compares entries from position zero;
// each move is one read and one write of the key memory; busy drops in the strobe cycle,
// so the next request may start then; done is a one-cycle strobe, the receiver cannot stall
// async active-low reset clears the count, sets the limit to 256, idles the sequencer; keys stay
module sorted_array_table_unit
    import sat_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32,
    localparam int IDX_W    = $clog2(DEPTH),
    localparam int CNT_W    = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           kind,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [IDX_W-1:0]     index,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 done,
    output logic [1:0]           status,
    output logic [KEY_WIDTH-1:0] entry,
    output logic [CNT_W-1:0]     count
);

    cmd_t  cmd;
    stat_t stat;

    sat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sat_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_kind   (kind),
        .in_key    (key),
        .in_index  (index),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .status    (status),
        .entry     (entry),
        .count     (count),
        .done      (done)
    );

endmodule
